### hdl/amd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the adjacency matrix DFS unit.
// Used by every module of the block; depends on nothing.
package amd_pkg;

    localparam int VERT_W        = 5;   // vertex field width
    localparam int NEXT_W        = 6;   // scan index and count width
    localparam int CMD_W         = 2;
    localparam int STACK_SLOTS   = 32;
    localparam int STACK_AW      = 5;
    localparam int RESULT_LIMIT  = 32;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int VCOUNT_RESET  = 32;

    localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRAVERSE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

    localparam logic REG_VERTEX_COUNT = 1'b0;  // paddr[2] of the only register

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_WA,
        S_EDGE_WB,
        S_ROW,
        S_SCAN,
        S_POP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              found;
        logic [NEXT_W-1:0] index;
    } t_scan;

endpackage

### hdl/amd_cmd_if.sv
`timescale 1ns / 1ps
// Command channel of the DFS unit: valid/ready and one command word.
// Depends on amd_pkg.
interface amd_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [amd_pkg::CMD_W-1:0]  command;
    logic [amd_pkg::VERT_W-1:0] vertex_a;
    logic [amd_pkg::VERT_W-1:0] vertex_b;

    modport source (output valid, command, vertex_a, vertex_b, input ready);
    modport sink   (input valid, command, vertex_a, vertex_b, output ready);
endinterface

### hdl/amd_res_if.sv
`timescale 1ns / 1ps
// Result channel of the DFS unit: valid/ready and one visit word.
// Depends on amd_pkg.
interface amd_res_if;
    logic                      valid;
    logic                      ready;
    logic [amd_pkg::VERT_W-1:0] visited_vertex;
    logic                      last;
    logic                      error;

    modport source (output valid, visited_vertex, last, error, input ready);
    modport sink   (input valid, visited_vertex, last, error, output ready);
endinterface

### hdl/amd_scan.sv
`timescale 1ns / 1ps
// Neighbor search: lowest unvisited neighbor at or above a start index.
// Depends on amd_pkg.
module amd_scan #(
    parameter int MAX_VERTICES = 32
) (
    input  logic [MAX_VERTICES-1:0]                   i_row,
    input  logic [MAX_VERTICES-1:0]                   i_visited,
    input  logic [amd_pkg::NEXT_W-1:0]                i_from,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]         i_count,
    output amd_pkg::t_scan                            o_scan
);

    logic [MAX_VERTICES-1:0] w_cand;

    always_comb begin
        for (int k = 0; k < MAX_VERTICES; k++) begin
            w_cand[k] = i_row[k] && !i_visited[k]
                        && (k >= int'(i_from)) && (k < int'(i_count));
        end
    end

    always_comb begin
        o_scan.found = |w_cand;
        o_scan.index = '0;
        for (int k = MAX_VERTICES - 1; k >= 0; k--) begin
            if (w_cand[k]) begin
                o_scan.index = amd_pkg::NEXT_W'(k);
            end
        end
    end

endmodule

### hdl/adjacency_matrix_dfs_unit.sv
`timescale 1ns / 1ps
// Depth-first search over a bit adjacency matrix held in on-chip memory.
// Channels: i_cmd takes command words (add edge, traverse, clear), o_res
// gives visit words; both are valid/ready. An APB-style port holds the
// vertex_count register at address 0.
// One command is worked at a time. Add edge passes through S_EDGE_RD, S_EDGE_WA
// and S_EDGE_WB before the next ready; clear completes in S_IDLE. A traverse
// from a valid start gives one word per visited vertex in DFS order, the final
// one with last set; each newly found vertex passes through S_ROW and S_SCAN
// and each backtrack through S_POP, S_ROW and S_SCAN, with one matrix row read
// per scan step. A bad start gives a single error word from S_DONE.
// Results pass through a pending word and an output register, so the walk runs
// on while a word waits; when the receiver stalls the walk holds at its next
// find until the output register frees. Reset clears the matrix (row valid
// bits), the walk state and the output, and sets vertex_count to 32.
// Depends on amd_pkg, amd_cmd_if, amd_res_if and amd_scan.
module adjacency_matrix_dfs_unit #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    amd_cmd_if.sink                             i_cmd,
    amd_res_if.source                           o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [amd_pkg::APB_AW-1:0]          paddr,
    input  logic [amd_pkg::APB_DW-1:0]          pwdata,
    output logic [amd_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NW = amd_pkg::NEXT_W;
    localparam int SW = VW + NW;

    amd_pkg::t_state r_state, n_state;

    logic [NW-1:0]           r_vcount;
    logic [CW-1:0]           w_n;
    logic [amd_pkg::VERT_W-1:0] r_a, r_b;

    logic [MAX_VERTICES-1:0] r_rows_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_rows_ok, n_rows_ok;
    logic [MAX_VERTICES-1:0] r_row_q;
    logic                    r_row_ok_q;
    logic [MAX_VERTICES-1:0] w_row;
    logic                    w_row_we;
    logic [VW-1:0]           w_row_waddr, w_row_raddr;
    logic [MAX_VERTICES-1:0] w_row_wdata;

    logic [SW-1:0]           r_stk_mem [amd_pkg::STACK_SLOTS];
    logic [SW-1:0]           r_stk_q;
    logic                    w_stk_we;
    logic [amd_pkg::STACK_AW-1:0] w_stk_waddr, w_stk_raddr;
    logic [SW-1:0]           w_stk_wdata;

    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [VW-1:0]           r_top_v, n_top_v;
    logic [NW-1:0]           r_top_next, n_top_next;
    logic [NW-1:0]           r_depth, n_depth;
    logic [NW-1:0]           r_cnt, n_cnt;

    logic                    r_pend_valid, n_pend_valid;
    logic [NW-1:0]           r_pend_v, n_pend_v;
    logic                    r_pend_err, n_pend_err;

    logic                    r_out_valid, n_out_valid;
    logic [amd_pkg::VERT_W-1:0] r_out_v, n_out_v;
    logic                    r_out_last, n_out_last;
    logic                    r_out_err, n_out_err;

    logic                    w_accept, w_can_flush, w_cfg_we;
    logic                    w_a_ok, w_b_ok;
    logic [MAX_VERTICES-1:0] w_bit_a, w_bit_b, w_bit_j;
    amd_pkg::t_scan          w_scan;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite
                      && (paddr[2] == amd_pkg::REG_VERTEX_COUNT);
    assign prdata   = (paddr[2] == amd_pkg::REG_VERTEX_COUNT)
                      ? amd_pkg::APB_DW'(r_vcount) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= NW'(amd_pkg::VCOUNT_RESET);
        end else if (w_cfg_we) begin
            r_vcount <= pwdata[NW-1:0];
        end
    end

    assign w_n = (int'(r_vcount) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(r_vcount);

    assign w_accept     = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready  = (r_state == amd_pkg::S_IDLE);
    assign w_can_flush  = !r_out_valid || o_res.ready;
    assign w_a_ok       = int'(i_cmd.vertex_a) < int'(w_n);
    assign w_b_ok       = int'(i_cmd.vertex_b) < int'(w_n);
    assign w_row        = r_row_ok_q ? r_row_q : '0;

    assign o_res.valid          = r_out_valid;
    assign o_res.visited_vertex = r_out_v;
    assign o_res.last           = r_out_last;
    assign o_res.error          = r_out_err;

    amd_scan #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_scan (
        .i_row     (w_row),
        .i_visited (r_visited),
        .i_from    (r_top_next),
        .i_count   (w_n),
        .o_scan    (w_scan)
    );

    always_comb begin
        w_bit_a = '0;
        w_bit_b = '0;
        w_bit_j = '0;
        w_bit_a[VW'(r_a)]          = 1'b1;
        w_bit_b[VW'(r_b)]          = 1'b1;
        w_bit_j[VW'(w_scan.index)] = 1'b1;
    end

    // Matrix memory
    always_ff @(posedge i_clk) begin
        if (w_row_we) begin
            r_rows_mem[w_row_waddr] <= w_row_wdata;
        end
        r_row_q    <= r_rows_mem[w_row_raddr];
        r_row_ok_q <= r_rows_ok[w_row_raddr];
    end

    // Stack memory
    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stk_mem[w_stk_waddr] <= w_stk_wdata;
        end
        r_stk_q <= r_stk_mem[w_stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= amd_pkg::S_IDLE;
            r_rows_ok    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_depth      <= '0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_rows_ok    <= n_rows_ok;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_depth      <= n_depth;
            r_cnt        <= n_cnt;
        end
        if (w_accept) begin
            r_a <= i_cmd.vertex_a;
            r_b <= i_cmd.vertex_b;
        end
        r_visited  <= n_visited;
        r_top_v    <= n_top_v;
        r_top_next <= n_top_next;
        r_pend_v   <= n_pend_v;
        r_pend_err <= n_pend_err;
        r_out_v    <= n_out_v;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    always_comb begin
        n_state      = r_state;
        n_rows_ok    = r_rows_ok;
        n_visited    = r_visited;
        n_top_v      = r_top_v;
        n_top_next   = r_top_next;
        n_depth      = r_depth;
        n_cnt        = r_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_v     = r_pend_v;
        n_pend_err   = r_pend_err;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_v      = r_out_v;
        n_out_last   = r_out_last;
        n_out_err    = r_out_err;
        w_row_we     = 1'b0;
        w_row_waddr  = VW'(r_a);
        w_row_wdata  = w_row;
        w_row_raddr  = r_top_v;
        w_stk_we     = 1'b0;
        w_stk_waddr  = amd_pkg::STACK_AW'(r_depth - 1'b1);
        w_stk_wdata  = {r_top_v, NW'(w_scan.index + 1'b1)};
        w_stk_raddr  = amd_pkg::STACK_AW'(r_depth - 2'd2);

        unique case (r_state)
            amd_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_cmd.command)
                        amd_pkg::CMD_ADD_EDGE: begin
                            if (w_a_ok && w_b_ok) begin
                                n_state = amd_pkg::S_EDGE_RD;
                            end
                        end
                        amd_pkg::CMD_TRAVERSE: begin
                            n_pend_valid = 1'b1;
                            if (w_a_ok) begin
                                n_visited                       = '0;
                                n_visited[VW'(i_cmd.vertex_a)]  = 1'b1;
                                n_top_v      = VW'(i_cmd.vertex_a);
                                n_top_next   = '0;
                                n_depth      = NW'(1);
                                n_cnt        = NW'(1);
                                n_pend_v     = NW'(i_cmd.vertex_a);
                                n_pend_err   = 1'b0;
                                n_state      = amd_pkg::S_ROW;
                            end else begin
                                n_pend_v     = '0;
                                n_pend_err   = 1'b1;
                                n_state      = amd_pkg::S_DONE;
                            end
                        end
                        amd_pkg::CMD_CLEAR: begin
                            n_rows_ok = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            amd_pkg::S_EDGE_RD: begin
                w_row_raddr = VW'(r_a);
                n_state     = amd_pkg::S_EDGE_WA;
            end
            amd_pkg::S_EDGE_WA: begin
                w_row_we                 = 1'b1;
                w_row_waddr              = VW'(r_a);
                w_row_wdata              = w_row | w_bit_b;
                n_rows_ok[VW'(r_a)]      = 1'b1;
                w_row_raddr              = VW'(r_b);
                n_state                  = amd_pkg::S_EDGE_WB;
            end
            amd_pkg::S_EDGE_WB: begin
                w_row_we                 = 1'b1;
                w_row_waddr              = VW'(r_b);
                w_row_wdata              = w_row | w_bit_a;
                n_rows_ok[VW'(r_b)]      = 1'b1;
                n_state                  = amd_pkg::S_IDLE;
            end
            amd_pkg::S_ROW: begin
                n_state = amd_pkg::S_SCAN;
            end
            amd_pkg::S_SCAN: begin
                if (w_scan.found) begin
                    if ((int'(r_cnt) < amd_pkg::RESULT_LIMIT)
                            && (int'(r_depth) < amd_pkg::STACK_SLOTS)) begin
                        if (w_can_flush) begin
                            n_out_valid = 1'b1;
                            n_out_v     = r_pend_v[amd_pkg::VERT_W-1:0];
                            n_out_last  = 1'b0;
                            n_out_err   = r_pend_err;
                            n_pend_v    = w_scan.index;
                            n_pend_err  = 1'b0;
                            w_stk_we    = 1'b1;
                            n_top_v     = VW'(w_scan.index);
                            n_top_next  = '0;
                            n_depth     = r_depth + 1'b1;
                            n_cnt       = r_cnt + 1'b1;
                            n_visited   = r_visited | w_bit_j;
                            w_row_raddr = VW'(w_scan.index);
                            n_state     = amd_pkg::S_ROW;
                        end
                    end else begin
                        n_depth = '0;
                        n_state = amd_pkg::S_DONE;
                    end
                end else if (r_depth == NW'(1)) begin
                    n_depth = '0;
                    n_state = amd_pkg::S_DONE;
                end else begin
                    n_depth = r_depth - 1'b1;
                    n_state = amd_pkg::S_POP;
                end
            end
            amd_pkg::S_POP: begin
                n_top_v    = r_stk_q[SW-1:NW];
                n_top_next = r_stk_q[NW-1:0];
                n_state    = amd_pkg::S_ROW;
            end
            amd_pkg::S_DONE: begin
                if (w_can_flush) begin
                    n_out_valid  = 1'b1;
                    n_out_v      = r_pend_v[amd_pkg::VERT_W-1:0];
                    n_out_last   = 1'b1;
                    n_out_err    = r_pend_err;
                    n_pend_valid = 1'b0;
                    n_state      = amd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = amd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hdl/amd_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the DFS unit, bound onto the top level.
// Depends on amd_pkg, adjacency_matrix_dfs_unit and its channel interfaces.
module amd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cmd_valid,
    input logic                      i_cmd_ready,
    input logic [amd_pkg::CMD_W-1:0] i_cmd_command,
    input logic                      i_res_valid,
    input logic                      i_res_ready,
    input logic [4:0]                i_res_vertex,
    input logic                      i_res_last,
    input logic                      i_res_error
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_vertex)
            && $stable(i_res_last) && $stable(i_res_error))
        else $error("result word changed while stalled");

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready && (i_cmd_command == amd_pkg::CMD_TRAVERSE)
            |=> !i_cmd_ready)
        else $error("command taken while previous one still in work");

    a_walk_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_last |-> !i_cmd_ready)
        else $error("ready before last word of a walk");

    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_error |-> i_res_last && (i_res_vertex == 5'd0))
        else $error("error word malformed");

endmodule

bind adjacency_matrix_dfs_unit amd_checker u_amd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (i_cmd.valid),
    .i_cmd_ready   (i_cmd.ready),
    .i_cmd_command (i_cmd.command),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_vertex  (o_res.visited_vertex),
    .i_res_last    (o_res.last),
    .i_res_error   (o_res.error)
);

### verif/amd_dfs_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the adjacency matrix DFS unit: mirrors the matrix and vertex_count,
// predicts the visit words of every traverse word and compares them in order.
// Depends on amd_pkg, amd_cmd_if and amd_res_if.
module amd_dfs_checker #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    amd_cmd_if                         i_cmd,
    amd_res_if                         i_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [amd_pkg::APB_AW-1:0] paddr,
    input  logic [amd_pkg::APB_DW-1:0] pwdata,
    input  logic                       pready,
    output int                         o_fail_count,
    output int                         o_words_pending
);

    typedef struct packed {
        logic [amd_pkg::VERT_W-1:0] vertex;
        logic                       last;
        logic                       error;
    } t_visit;

    logic [MAX_VERTICES-1:0]    adj_rows [MAX_VERTICES];
    logic [amd_pkg::NEXT_W-1:0] vertex_count;
    t_visit                     visits_due [$];

    function automatic int live_vertices();
        return (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
    endfunction

    task automatic push_visit(input int v, input logic is_last, input logic is_err);
        t_visit w;
        logic [31:0] vbits;
        vbits = v;
        w.vertex = vbits[amd_pkg::VERT_W-1:0];
        w.last   = is_last;
        w.error  = is_err;
        visits_due.push_back(w);
    endtask

    task automatic predict_walk(input int start, input int n);
        logic [MAX_VERTICES-1:0] seen;
        int                      stk_v [amd_pkg::STACK_SLOTS];
        int                      stk_n [amd_pkg::STACK_SLOTS];
        int                      order [$];
        int                      depth;
        int                      top;
        int                      u;
        int                      hit;
        bit                      found;
        seen        = '0;
        seen[start] = 1'b1;
        order.push_back(start);
        stk_v[0] = start;
        stk_n[0] = 0;
        depth    = 1;
        while (depth > 0) begin
            top   = (depth - 1) % amd_pkg::STACK_SLOTS;
            u     = stk_v[top];
            found = 1'b0;
            hit   = 0;
            for (int j = stk_n[top]; j < n; j++) begin
                if (!found && adj_rows[u][j] && !seen[j]) begin
                    found = 1'b1;
                    hit   = j;
                end
            end
            if (found && order.size() < amd_pkg::RESULT_LIMIT
                    && depth < amd_pkg::STACK_SLOTS) begin
                stk_n[top] = hit + 1;
                seen[hit]  = 1'b1;
                order.push_back(hit);
                stk_v[depth] = hit;
                stk_n[depth] = 0;
                depth++;
            end else if (found) begin
                depth = 0;
            end else begin
                depth--;
            end
        end
        for (int k = 0; k < order.size(); k++) begin
            push_visit(order[k], k == order.size() - 1, 1'b0);
        end
    endtask

    task automatic apply_command(input logic [amd_pkg::CMD_W-1:0] c, input int a,
                                 input int b);
        int n;
        n = live_vertices();
        case (c)
            amd_pkg::CMD_ADD_EDGE: begin
                if (a < n && b < n) begin
                    adj_rows[a][b] = 1'b1;
                    adj_rows[b][a] = 1'b1;
                end
            end
            amd_pkg::CMD_CLEAR: begin
                for (int r = 0; r < MAX_VERTICES; r++) adj_rows[r] = '0;
            end
            amd_pkg::CMD_TRAVERSE: begin
                if (a >= n) begin
                    push_visit(0, 1'b1, 1'b1);
                end else begin
                    predict_walk(a, n);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_visit want;
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_VERTICES; r++) adj_rows[r] = '0;
            vertex_count = amd_pkg::NEXT_W'(amd_pkg::VCOUNT_RESET);
            visits_due.delete();
            o_fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready
                    && paddr[2] == amd_pkg::REG_VERTEX_COUNT) begin
                vertex_count = pwdata[amd_pkg::NEXT_W-1:0];
            end
            if (i_cmd.valid && i_cmd.ready) begin
                apply_command(i_cmd.command, int'(i_cmd.vertex_a),
                              int'(i_cmd.vertex_b));
            end
            if (i_res.valid && i_res.ready) begin
                if (visits_due.size() == 0) begin
                    o_fail_count++;
                    $display(
                        "%0t: unexpected word: expected none, got %0d last %0b error %0b",
                        $time, i_res.visited_vertex, i_res.last, i_res.error);
                end else begin
                    want = visits_due.pop_front();
                    if (i_res.visited_vertex !== want.vertex) begin
                        o_fail_count++;
                        $display("%0t: visited_vertex mismatch: expected %0d, got %0d",
                                 $time, want.vertex, i_res.visited_vertex);
                    end
                    if (i_res.last !== want.last) begin
                        o_fail_count++;
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, want.last, i_res.last);
                    end
                    if (i_res.error !== want.error) begin
                        o_fail_count++;
                        $display("%0t: error mismatch: expected %0b, got %0b",
                                 $time, want.error, i_res.error);
                    end
                end
            end
        end
        o_words_pending = visits_due.size();
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the DFS unit testbench: clock, reset, command words, register writes,
// receiver stalls and the verdict.
// Depends on amd_pkg, amd_cmd_if, amd_res_if, the DFS unit and amd_dfs_checker.
module tb_top;

    localparam int                        MAX_V         = 32;
    localparam logic [amd_pkg::CMD_W-1:0] CMD_UNUSED    = 2'd3;
    localparam int                        SETTLE_CYCLES = 16;
    localparam int                        DRAIN_CYCLES  = 200;
    localparam int                        HOLD_CYCLES   = 400;
    localparam int                        LIMIT_CYCLES  = 800000;
    localparam int                        PHASE_WORDS   = 45;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [amd_pkg::APB_AW-1:0] paddr = '0;
    logic [amd_pkg::APB_DW-1:0] pwdata = '0;
    logic [amd_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    int     fail_count;
    int     words_pending;
    int     cycle_count = 0;
    int     burst_left = 0;
    bit     gaps_on = 1'b1;
    bit     hold_req = 1'b0;
    t_stall rx_style = STALL_NONE;
    int     rx_span = 0;

    amd_cmd_if cmd_bus ();
    amd_res_if res_bus ();

    adjacency_matrix_dfs_unit #(.MAX_VERTICES(MAX_V)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    amd_dfs_checker #(.MAX_VERTICES(MAX_V)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_bus),
        .i_res           (res_bus),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: stall style changes every span; a requested hold blocks it for long
    initial begin
        res_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req      = 1'b0;
                res_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (rx_span == 0) begin
                rx_style = t_stall'($urandom_range(0, 3));
                rx_span  = $urandom_range(20, 150);
            end
            rx_span--;
            case (rx_style)
                STALL_NONE:  res_bus.ready = 1'b1;
                STALL_LIGHT: res_bus.ready = ($urandom_range(0, 3) != 0);
                STALL_HEAVY: res_bus.ready = ($urandom_range(0, 3) == 0);
                default:     res_bus.ready = (rx_span % 3 == 0);
            endcase
        end
    end

    task automatic put_word(input logic [amd_pkg::CMD_W-1:0] c, input int a, input int b);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                cmd_bus.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        cmd_bus.valid    = 1'b1;
        cmd_bus.command  = c;
        cmd_bus.vertex_a = a[amd_pkg::VERT_W-1:0];
        cmd_bus.vertex_b = b[amd_pkg::VERT_W-1:0];
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic settle();
        cmd_bus.valid = 1'b0;
        while (words_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_count(input int v);
        settle();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {amd_pkg::REG_VERTEX_COUNT, 2'b00};
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic int pick_vertex(input int n);
        if (n == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, MAX_V - 1);
        return $urandom_range(0, n - 1);
    endfunction

    task automatic random_phase(input int count_value, input bit with_hold);
        int n;
        int sent;
        int pick;
        int j;
        int tmp;
        bit hold_sent;
        int perm [MAX_V];
        write_count(count_value);
        n         = (count_value > MAX_V) ? MAX_V : count_value;
        gaps_on   = ($urandom_range(0, 3) != 0);
        sent      = 0;
        hold_sent = 1'b0;
        while (sent < PHASE_WORDS) begin
            if (with_hold && !hold_sent && sent >= PHASE_WORDS / 2) begin
                hold_req  = 1'b1;
                hold_sent = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 6 && n > 1) begin
                // path over a shuffled vertex order, then walk it
                for (int k = 0; k < n; k++) perm[k] = k;
                for (int k = n - 1; k > 0; k--) begin
                    j       = $urandom_range(0, k);
                    tmp     = perm[k];
                    perm[k] = perm[j];
                    perm[j] = tmp;
                end
                put_word(amd_pkg::CMD_CLEAR, pick_vertex(n), pick_vertex(n));
                for (int k = 1; k < n; k++) begin
                    put_word(amd_pkg::CMD_ADD_EDGE, perm[k - 1], perm[k]);
                end
                put_word(amd_pkg::CMD_TRAVERSE, perm[$urandom_range(0, n - 1)],
                         $urandom_range(0, 31));
                sent += n + 1;
            end else if (pick < 62) begin
                put_word(amd_pkg::CMD_ADD_EDGE, pick_vertex(n), pick_vertex(n));
                sent++;
            end else if (pick < 88) begin
                put_word(amd_pkg::CMD_TRAVERSE, pick_vertex(n), $urandom_range(0, 31));
                sent++;
            end else if (pick < 93) begin
                put_word(amd_pkg::CMD_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31));
                sent++;
            end else if (pick < 96) begin
                put_word(CMD_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31));
                sent++;
            end else begin
                put_word(amd_pkg::CMD_ADD_EDGE, $urandom_range(0, 31),
                         $urandom_range(0, 31));
                sent++;
            end
        end
    endtask

    initial begin
        cmd_bus.valid    = 1'b0;
        cmd_bus.command  = amd_pkg::CMD_ADD_EDGE;
        cmd_bus.vertex_a = '0;
        cmd_bus.vertex_b = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        put_word(amd_pkg::CMD_TRAVERSE, 0, 0);
        put_word(amd_pkg::CMD_TRAVERSE, 31, 31);
        put_word(amd_pkg::CMD_ADD_EDGE, 0, 31);
        put_word(amd_pkg::CMD_ADD_EDGE, 31, 5);
        put_word(amd_pkg::CMD_ADD_EDGE, 5, 5);
        put_word(amd_pkg::CMD_ADD_EDGE, 0, 1);
        put_word(amd_pkg::CMD_ADD_EDGE, 1, 31);
        put_word(CMD_UNUSED, 31, 31);
        put_word(amd_pkg::CMD_TRAVERSE, 0, 0);
        put_word(amd_pkg::CMD_TRAVERSE, 5, 0);
        put_word(amd_pkg::CMD_CLEAR, 0, 0);
        put_word(amd_pkg::CMD_TRAVERSE, 31, 0);
        put_word(amd_pkg::CMD_ADD_EDGE, 2, 20);
        put_word(amd_pkg::CMD_ADD_EDGE, 2, 3);
        put_word(amd_pkg::CMD_ADD_EDGE, 20, 9);
        write_count(10);
        put_word(amd_pkg::CMD_TRAVERSE, 2, 0);
        put_word(amd_pkg::CMD_ADD_EDGE, 9, 20);
        put_word(amd_pkg::CMD_ADD_EDGE, 4, 12);
        put_word(amd_pkg::CMD_TRAVERSE, 12, 0);
        write_count(0);
        put_word(amd_pkg::CMD_TRAVERSE, 0, 0);
        put_word(amd_pkg::CMD_ADD_EDGE, 0, 0);
        write_count(1);
        put_word(amd_pkg::CMD_TRAVERSE, 0, 0);
        put_word(amd_pkg::CMD_TRAVERSE, 1, 0);
        write_count(63);
        put_word(amd_pkg::CMD_TRAVERSE, 20, 0);
        put_word(amd_pkg::CMD_ADD_EDGE, 31, 30);

        random_phase(32, 1'b1);
        random_phase(8, 1'b0);
        random_phase(63, 1'b0);
        random_phase(1, 1'b0);
        random_phase(20, 1'b0);
        random_phase(0, 1'b0);
        random_phase(33, 1'b0);
        random_phase(2, 1'b0);
        random_phase(32, 1'b0);
        random_phase(12, 1'b0);

        cmd_bus.valid = 1'b0;
        while (words_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && words_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
